// ===== src/inverted_ellipse_point_and_tangent_macros.svh =====
// Assertion helpers; clk and rst_n are taken from the module that uses them.
`ifndef INVERTED_ELLIPSE_POINT_AND_TANGENT_MACROS_SVH
`define INVERTED_ELLIPSE_POINT_AND_TANGENT_MACROS_SVH
`ifndef SYNTHESIS
`define IEPT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define IEPT_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
    else $error("latency check failed");
`else
`define IEPT_ASSERT_IMP(lbl, ante, cons)
`define IEPT_ASSERT_DLY(lbl, ante, n, cons)
`endif
`endif

// ===== src/iept_pkg.sv =====
package iept_pkg;

  // angle and fraction widths
  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TURN_W     = 32;

  // CORDIC
  localparam int CORDIC_ITERS = 24;
  localparam int CORDIC_W     = 34;
  localparam int CS_W         = 32;
  localparam int CORDIC_LAT   = CORDIC_ITERS + 2;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // configuration
  localparam int AX_W       = 16;
  localparam int CEN_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam logic [AX_W-1:0] AX_RESET = 16'd32768;

  // datapath widths
  localparam int AX_SH = 16;
  localparam int Q30   = 30;
  localparam int AC_W  = CS_W + 1;
  localparam int P_W   = AC_W + CS_W;
  localparam int WN_W  = 34;
  localparam int SQ_W  = 2 * WN_W;
  localparam int C2_W  = 36;
  localparam int QP_W  = WN_W + C2_W;
  localparam int NUM_W = 64;
  localparam int DEN_W = 64;
  localparam int WM_LAT = 7;

  // divider
  localparam int SH_PT     = Q30 + FRAC_BITS;
  localparam int SH_SL     = Q30;
  localparam int CAP_BITS  = 40;
  localparam int DIV_STEPS = CAP_BITS + 1;
  localparam int QUO_W     = CAP_BITS + 2;
  localparam int X_W       = NUM_W + SH_PT;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam logic signed [QUO_W-1:0] QUO_CAP = {2'b01, {CAP_BITS{1'b0}}};

  // output
  localparam int OUT_W = 32;
  localparam int CEN_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int CEN_SHR = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;
  localparam int TOTAL_LAT = CORDIC_LAT + WM_LAT + 2 * DIV_LAT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE  = 2'd0,
    REG_CENTER_IM  = 2'd1,
    REG_AXIS_RATIO = 2'd2,
    REG_ROTATION   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    vld;
    logic                    degen;
    logic signed [WN_W-1:0]  a;
    logic signed [WN_W-1:0]  nb;
    logic [DEN_W-1:0]        n;
    logic signed [NUM_W-1:0] pre;
    logic signed [NUM_W-1:0] pim;
  } wm_out_t;

  typedef struct packed {
    logic                    vld;
    logic signed [QUO_W-1:0] quo;
  } div_out_t;

  // arctangent table in units of 2^-32 turn
  function automatic logic signed [CORDIC_W-1:0] atan_turns(input int idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      0:  v = 34'sd536870912;
      1:  v = 34'sd316933406;
      2:  v = 34'sd167458907;
      3:  v = 34'sd85004756;
      4:  v = 34'sd42667331;
      5:  v = 34'sd21354465;
      6:  v = 34'sd10679838;
      7:  v = 34'sd5340245;
      8:  v = 34'sd2670163;
      9:  v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/iept_cordic.sv =====
// Pipelined CORDIC: one rotation step per stage, cos/sin in Q30.
module iept_cordic import iept_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [TURN_W-1:0]      angle,
  output logic                   out_valid,
  output logic signed [CS_W-1:0] cos_o,
  output logic signed [CS_W-1:0] sin_o
);

  logic                       vld_r  [0:CORDIC_ITERS];
  logic                       flip_r [0:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] x_r    [0:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] y_r    [0:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] z_r    [0:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] x_nxt  [1:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] y_nxt  [1:CORDIC_ITERS];
  logic signed [CORDIC_W-1:0] z_nxt  [1:CORDIC_ITERS];
  logic [TURN_W-1:0]          quad_sum;
  logic [TURN_W-1:0]          ang_fold;
  logic                       flip;
  logic                       out_vld_r;
  logic signed [CS_W-1:0]     cos_r, sin_r;

  // fold the angle into the right half plane
  always_comb begin
    quad_sum = angle + 32'h4000_0000;
    flip     = quad_sum[TURN_W-1];
    ang_fold = flip ? angle + 32'h8000_0000 : angle;
  end

  // rotation steps
  always_comb begin
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (!z_r[i][CORDIC_W-1]) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - atan_turns(i);
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + atan_turns(i);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_ITERS; i++) vld_r[i] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= CORDIC_ITERS; i++) vld_r[i] <= vld_r[i-1];
      out_vld_r <= vld_r[CORDIC_ITERS];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    x_r[0]    <= CORDIC_GAIN;
    y_r[0]    <= '0;
    z_r[0]    <= CORDIC_W'($signed(ang_fold));
    flip_r[0] <= flip;
    for (int i = 1; i <= CORDIC_ITERS; i++) begin
      x_r[i]    <= x_nxt[i];
      y_r[i]    <= y_nxt[i];
      z_r[i]    <= z_nxt[i];
      flip_r[i] <= flip_r[i-1];
    end
    cos_r <= CS_W'(flip_r[CORDIC_ITERS] ? -x_r[CORDIC_ITERS] : x_r[CORDIC_ITERS]);
    sin_r <= CS_W'(flip_r[CORDIC_ITERS] ? -y_r[CORDIC_ITERS] : y_r[CORDIC_ITERS]);
  end

  assign out_valid = out_vld_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;

endmodule

// ===== src/iept_wmath.sv =====
// Forms w, the numerator, |w|^2 and N*conj(w)^2 over seven stages.
module iept_wmath import iept_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic signed [CS_W-1:0] cos_t,
  input  logic signed [CS_W-1:0] sin_t,
  input  logic signed [CS_W-1:0] cos_r,
  input  logic signed [CS_W-1:0] sin_r,
  input  logic [AX_W-1:0]        axis,
  output wm_out_t                res
);

  logic                     vld_r [1:WM_LAT];
  // stage 1
  logic signed [AX_W+CS_W:0] acr_full, asr_full;
  logic signed [AC_W-1:0]    acr_r, asr_r;
  logic signed [CS_W-1:0]    ct1_r, st1_r, cr1_r, sr1_r;
  // stage 2
  logic signed [P_W-1:0]     p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r, p8_r;
  // stage 3
  logic signed [P_W:0]       s_a, s_b, s_re, s_im;
  logic signed [WN_W-1:0]    a3_r, nb3_r, nre3_r, nim3_r;
  // stage 4
  logic signed [SQ_W-1:0]    aa_r, bb_r, ab_r;
  logic signed [WN_W-1:0]    a4_r, nb4_r, nre4_r, nim4_r;
  // stage 5
  logic signed [SQ_W:0]      d_sq, ab2;
  logic [DEN_W-1:0]          n5_r;
  logic signed [C2_W-1:0]    c2re_r, c2im_r;
  logic signed [WN_W-1:0]    a5_r, nb5_r, nre5_r, nim5_r;
  // stage 6
  logic signed [QP_W-1:0]    q1_r, q2_r, q3_r, q4_r;
  logic signed [WN_W-1:0]    a6_r, nb6_r;
  logic [DEN_W-1:0]          n6_r;
  logic                      deg6_r;
  // stage 7
  logic signed [NUM_W-1:0]   pre_r, pim_r;
  logic signed [WN_W-1:0]    a7_r, nb7_r;
  logic [DEN_W-1:0]          n7_r;
  logic                      deg7_r;

  // combinational pieces between stages
  always_comb begin
    acr_full = $signed({1'b0, axis}) * cos_r;
    asr_full = $signed({1'b0, axis}) * sin_r;
    s_a  = p1_r - p2_r;
    s_b  = p3_r + p4_r;
    s_re = p5_r + p6_r;
    s_im = p7_r - p8_r;
    d_sq = aa_r - bb_r;
    ab2  = ab_r <<< 1;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= WM_LAT; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[1] <= in_valid;
      for (int i = 2; i <= WM_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    // alpha scaling
    acr_r <= AC_W'(acr_full >>> AX_SH);
    asr_r <= AC_W'(asr_full >>> AX_SH);
    ct1_r <= cos_t;
    st1_r <= sin_t;
    cr1_r <= cos_r;
    sr1_r <= sin_r;
    // cross products
    p1_r <= acr_r * ct1_r;
    p2_r <= sr1_r * st1_r;
    p3_r <= cr1_r * st1_r;
    p4_r <= asr_r * ct1_r;
    p5_r <= acr_r * st1_r;
    p6_r <= sr1_r * ct1_r;
    p7_r <= cr1_r * ct1_r;
    p8_r <= asr_r * st1_r;
    // w and numerator back to Q30
    a3_r   <= WN_W'(s_a >>> Q30);
    nb3_r  <= WN_W'(s_b >>> Q30);
    nre3_r <= WN_W'(s_re >>> Q30);
    nim3_r <= WN_W'(s_im >>> Q30);
    // squares
    aa_r   <= a3_r * a3_r;
    bb_r   <= nb3_r * nb3_r;
    ab_r   <= a3_r * nb3_r;
    a4_r   <= a3_r;
    nb4_r  <= nb3_r;
    nre4_r <= nre3_r;
    nim4_r <= nim3_r;
    // |w|^2 and conj(w)^2
    n5_r   <= DEN_W'(aa_r + bb_r);
    c2re_r <= C2_W'(d_sq >>> Q30);
    c2im_r <= C2_W'(ab2 >>> Q30);
    a5_r   <= a4_r;
    nb5_r  <= nb4_r;
    nre5_r <= nre4_r;
    nim5_r <= nim4_r;
    // N * conj(w)^2 partial products
    q1_r   <= nre5_r * c2re_r;
    q2_r   <= nim5_r * c2im_r;
    q3_r   <= nre5_r * c2im_r;
    q4_r   <= nim5_r * c2re_r;
    a6_r   <= a5_r;
    nb6_r  <= nb5_r;
    n6_r   <= n5_r;
    deg6_r <= (n5_r == '0);
    // sums
    pre_r  <= NUM_W'(q1_r - q2_r);
    pim_r  <= NUM_W'(q3_r + q4_r);
    a7_r   <= a6_r;
    nb7_r  <= nb6_r;
    n7_r   <= n6_r;
    deg7_r <= deg6_r;
  end

  assign res.vld   = vld_r[WM_LAT];
  assign res.degen = deg7_r;
  assign res.a     = a7_r;
  assign res.nb    = nb7_r;
  assign res.n     = n7_r;
  assign res.pre   = pre_r;
  assign res.pim   = pim_r;

endmodule

// ===== src/iept_div.sv =====
`include "inverted_ellipse_point_and_tangent_macros.svh"
// Pipelined restoring divider: num*2^sh/den, truncated, magnitude capped at 2^40.
// One quotient bit per stage.
module iept_div import iept_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  input  logic                    long_sh,
  output div_out_t                res
);

  logic                    vld_r [0:DIV_STEPS];
  logic                    neg_r [0:DIV_STEPS];
  logic                    ovf_r [0:DIV_STEPS];
  logic [DEN_W-1:0]        d_r   [0:DIV_STEPS];
  logic [DEN_W-1:0]        rem_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]    low_r [0:DIV_STEPS];
  logic [DIV_STEPS-1:0]    q_r   [0:DIV_STEPS];
  logic [DEN_W:0]          rs    [1:DIV_STEPS];
  logic [DEN_W-1:0]        rem_nxt [1:DIV_STEPS];
  logic [DIV_STEPS-1:0]    q_nxt   [1:DIV_STEPS];
  logic [NUM_W-1:0]        mag;
  logic [X_W-1:0]          xw, top;
  logic [QUO_W-1:0]        mq;
  logic signed [QUO_W-1:0] quo_nxt;
  logic                    out_vld_r;
  logic signed [QUO_W-1:0] quo_r;

  // operand setup: magnitude, shifted dividend, overflow precheck
  always_comb begin
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    xw  = long_sh ? (X_W'(mag) << SH_PT) : (X_W'(mag) << SH_SL);
    top = xw >> DIV_STEPS;
  end

  // one restoring step per stage
  always_comb begin
    for (int k = 1; k <= DIV_STEPS; k++) begin
      rs[k] = {rem_r[k-1], low_r[k-1][DIV_STEPS-1]};
      if (rs[k] >= {1'b0, d_r[k-1]}) begin
        rem_nxt[k] = DEN_W'(rs[k] - {1'b0, d_r[k-1]});
        q_nxt[k]   = {q_r[k-1][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = DEN_W'(rs[k]);
        q_nxt[k]   = {q_r[k-1][DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  // cap and sign
  always_comb begin
    mq = (ovf_r[DIV_STEPS] || q_r[DIV_STEPS][DIV_STEPS-1]) ?
         QUO_CAP : QUO_W'(q_r[DIV_STEPS]);
    quo_nxt = neg_r[DIV_STEPS] ? -$signed(mq) : $signed(mq);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) vld_r[k] <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= DIV_STEPS; k++) vld_r[k] <= vld_r[k-1];
      out_vld_r <= vld_r[DIV_STEPS];
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    neg_r[0] <= num[NUM_W-1];
    ovf_r[0] <= (top >= X_W'(den));
    d_r[0]   <= den;
    rem_r[0] <= DEN_W'(top);
    low_r[0] <= xw[DIV_STEPS-1:0];
    q_r[0]   <= '0;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      d_r[k]   <= d_r[k-1];
      rem_r[k] <= rem_nxt[k];
      low_r[k] <= {low_r[k-1][DIV_STEPS-2:0], 1'b0};
      q_r[k]   <= q_nxt[k];
    end
    quo_r <= quo_nxt;
  end

  assign res.vld = out_vld_r;
  assign res.quo = quo_r;

  `IEPT_ASSERT_IMP(div_quo_capped, out_vld_r, (quo_r <= QUO_CAP) && (quo_r >= -QUO_CAP))
  `IEPT_ASSERT_DLY(div_latency, in_valid, DIV_LAT, out_vld_r)

endmodule

// ===== src/inverted_ellipse_point_and_tangent.sv =====
// Path from start to out_valid: two 26-stage CORDICs, 7 product stages,
// two chained 43-stage dividers, one output register.
// Throughput: one angle per cycle; busy stays low, the pipeline never stalls.
// Reset (rst_n low, synchronous) drops all items in flight and restores the registers:
// center 0, axis ratio 32768, rotation 0.
`include "inverted_ellipse_point_and_tangent_macros.svh"
module inverted_ellipse_point_and_tangent import iept_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic [ANGLE_BITS-1:0]   in_angle_turns,
  // result channel
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_point_re,
  output logic signed [OUT_W-1:0] out_point_im,
  output logic signed [OUT_W-1:0] out_slope_re,
  output logic signed [OUT_W-1:0] out_slope_im,
  output logic                    out_clipped,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam logic signed [NUM_W-1:0] SAT_MAX = NUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [NUM_W-1:0] SAT_MIN = -NUM_W'(64'sh8000_0000);

  logic signed [CEN_W-1:0] center_re_r, center_im_r;
  logic [AX_W-1:0]         axis_r;
  logic [AX_W-1:0]         rot_r;

  logic                    t_vld, r_vld;
  logic signed [CS_W-1:0]  cos_t, sin_t, cos_rot, sin_rot;
  wm_out_t                 wm;
  div_out_t                dp_re, dp_im, ds1_re, ds1_im, ds2_re, ds2_im;

  logic [DEN_W-1:0]        n_dly_r   [0:DIV_LAT-1];
  logic signed [QUO_W-1:0] pre_dly_r [0:DIV_LAT-1];
  logic signed [QUO_W-1:0] pim_dly_r [0:DIV_LAT-1];
  logic                    deg_dly_r [0:2*DIV_LAT-1];

  logic signed [NUM_W-1:0] cqf_re, cqf_im, v0, v1, v2, v3;
  logic                    clip_nxt, degen;
  logic                    out_vld_r;
  logic signed [OUT_W-1:0] pre_o_r, pim_o_r, sre_o_r, sim_o_r;
  logic                    clip_r;

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_MAX) r = OUT_W'(SAT_MAX);
    else if (v < SAT_MIN) r = OUT_W'(SAT_MIN);
    else r = OUT_W'(v);
    return r;
  endfunction

  function automatic logic out_of_range(input logic signed [NUM_W-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_re_r <= '0;
      center_im_r <= '0;
      axis_r      <= AX_RESET;
      rot_r       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_RE:  center_re_r <= $signed(cfg_data[CEN_W-1:0]);
        REG_CENTER_IM:  center_im_r <= $signed(cfg_data[CEN_W-1:0]);
        REG_AXIS_RATIO: axis_r      <= cfg_data[AX_W-1:0];
        REG_ROTATION:   rot_r       <= cfg_data[AX_W-1:0];
      endcase
    end
  end

  // sine and cosine of curve angle and rotation
  iept_cordic u_cordic_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .angle     ({in_angle_turns, {(TURN_W-ANGLE_BITS){1'b0}}}),
    .out_valid (t_vld),
    .cos_o     (cos_t),
    .sin_o     (sin_t)
  );

  iept_cordic u_cordic_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .angle     ({rot_r, {(TURN_W-AX_W){1'b0}}}),
    .out_valid (r_vld),
    .cos_o     (cos_rot),
    .sin_o     (sin_rot)
  );

  iept_wmath u_wmath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (t_vld && r_vld),
    .cos_t    (cos_t),
    .sin_t    (sin_t),
    .cos_r    (cos_rot),
    .sin_r    (sin_rot),
    .axis     (axis_r),
    .res      (wm)
  );

  // point divisions and first slope divisions run side by side
  iept_div u_div_pre (
    .clk (clk), .rst_n (rst_n), .in_valid (wm.vld),
    .num (NUM_W'(wm.a)), .den (wm.n), .long_sh (1'b1), .res (dp_re)
  );

  iept_div u_div_pim (
    .clk (clk), .rst_n (rst_n), .in_valid (wm.vld),
    .num (NUM_W'(wm.nb)), .den (wm.n), .long_sh (1'b1), .res (dp_im)
  );

  iept_div u_div_s1re (
    .clk (clk), .rst_n (rst_n), .in_valid (wm.vld),
    .num (wm.pre), .den (wm.n), .long_sh (1'b0), .res (ds1_re)
  );

  iept_div u_div_s1im (
    .clk (clk), .rst_n (rst_n), .in_valid (wm.vld),
    .num (wm.pim), .den (wm.n), .long_sh (1'b0), .res (ds1_im)
  );

  // second slope divisions
  iept_div u_div_s2re (
    .clk (clk), .rst_n (rst_n), .in_valid (ds1_re.vld),
    .num (NUM_W'(ds1_re.quo)), .den (n_dly_r[DIV_LAT-1]), .long_sh (1'b1), .res (ds2_re)
  );

  iept_div u_div_s2im (
    .clk (clk), .rst_n (rst_n), .in_valid (ds1_im.vld),
    .num (NUM_W'(ds1_im.quo)), .den (n_dly_r[DIV_LAT-1]), .long_sh (1'b1), .res (ds2_im)
  );

  // alignment delay lines
  always_ff @(posedge clk) begin
    n_dly_r[0]   <= wm.n;
    pre_dly_r[0] <= dp_re.quo;
    pim_dly_r[0] <= dp_im.quo;
    deg_dly_r[0] <= wm.degen;
    for (int k = 1; k < DIV_LAT; k++) begin
      n_dly_r[k]   <= n_dly_r[k-1];
      pre_dly_r[k] <= pre_dly_r[k-1];
      pim_dly_r[k] <= pim_dly_r[k-1];
    end
    for (int k = 1; k < 2 * DIV_LAT; k++) deg_dly_r[k] <= deg_dly_r[k-1];
  end

  // center offset, final sums and saturation
  always_comb begin
    cqf_re   = (NUM_W'(center_re_r) <<< CEN_SHL) >>> CEN_SHR;
    cqf_im   = (NUM_W'(center_im_r) <<< CEN_SHL) >>> CEN_SHR;
    v0       = NUM_W'(pre_dly_r[DIV_LAT-1]) + cqf_re;
    v1       = NUM_W'(pim_dly_r[DIV_LAT-1]) + cqf_im;
    v2       = NUM_W'(ds2_re.quo);
    v3       = NUM_W'(ds2_im.quo);
    degen    = deg_dly_r[2*DIV_LAT-1];
    clip_nxt = out_of_range(v0) || out_of_range(v1) || out_of_range(v2) ||
               out_of_range(v3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= ds2_re.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (degen) begin
      pre_o_r <= OUT_W'(SAT_MAX);
      pim_o_r <= OUT_W'(SAT_MAX);
      sre_o_r <= OUT_W'(SAT_MAX);
      sim_o_r <= OUT_W'(SAT_MAX);
      clip_r  <= 1'b1;
    end else begin
      pre_o_r <= sat32(v0);
      pim_o_r <= sat32(v1);
      sre_o_r <= sat32(v2);
      sim_o_r <= sat32(v3);
      clip_r  <= clip_nxt;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_point_re = pre_o_r;
  assign out_point_im = pim_o_r;
  assign out_slope_re = sre_o_r;
  assign out_slope_im = sim_o_r;
  assign out_clipped  = clip_r;

  `IEPT_ASSERT_DLY(top_latency, start && !busy, TOTAL_LAT, out_valid)
  `IEPT_ASSERT_IMP(slope_lanes_aligned, ds2_re.vld || ds2_im.vld || dp_re.vld || ds1_re.vld, (ds2_re.vld == ds2_im.vld) && (dp_re.vld == ds1_re.vld) && (dp_im.vld == ds1_im.vld))

endmodule
